FILE: sv/lux_dimming_control_loop_core_macros.svh
// Assertion macros used by the lux dimming control loop checker
`ifndef LUX_DIMMING_CONTROL_LOOP_CORE_MACROS_SVH
`define LUX_DIMMING_CONTROL_LOOP_CORE_MACROS_SVH

// Checked only outside reset
`define LDCL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included
`define LDCL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/ldcl_pkg.sv
// Types, constants and the remote level table of the lux dimming control loop
package ldcl_pkg;

   // Fixed step timing
   localparam logic [7:0]  FAST_TICKS      = 8'd250;
   localparam logic [2:0]  DIV_EVERY_TICK  = 3'd0;
   localparam logic [2:0]  DIV_EVERY_2ND   = 3'd1;
   localparam logic [2:0]  DIV_EVERY_5TH   = 3'd4;
   localparam logic [14:0] ERR_FAST_LIMIT  = 15'd150;
   localparam logic [14:0] ERR_MID_LIMIT   = 15'd50;
   localparam logic [15:0] ERR_DEADBAND    = 16'd5;

   // Level limits
   localparam logic [9:0]  DIM_MAX         = 10'd1000;
   localparam logic [9:0]  DIM_RESTART     = 10'd200;
   localparam logic [7:0]  RAW_MAX         = 8'd254;
   localparam logic [22:0] TICKS_PER_SEC   = 23'd100;
   localparam logic [22:0] PERCENT_SCALE   = 23'd100;

   // Remote level scaling: level * 3938 / 1000, full byte maps to 1000
   localparam int unsigned RemoteMul = 3938;
   localparam int unsigned PerMille  = 1000;

   // Register reset values
   localparam logic        CTL_EN_RESET    = 1'b0;
   localparam logic [9:0]  MIN_DIM_RESET   = 10'd30;
   localparam logic [7:0]  PERCENT_RESET   = 8'd50;
   localparam logic [15:0] SECONDS_RESET   = 16'd300;
   localparam logic        RAW_MODE_RESET  = 1'b0;

   // Register indexes
   typedef enum logic [2:0] {
      CSR_CONTROLLER_ENABLE = 3'd0,
      CSR_MIN_DIM_LEVEL     = 3'd1,
      CSR_SAVING_PERCENT    = 3'd2,
      CSR_SAVING_SECONDS    = 3'd3,
      CSR_REMOTE_RAW_MODE   = 3'd4
   } csr_index_type;

   // Configuration as seen by the step logic
   typedef struct packed {
      logic        ctl_en;
      logic [9:0]  min_level;      // already saturated at DIM_MAX
      logic [7:0]  saving_percent;
      logic [22:0] saving_reload;  // 100 * saving_seconds
      logic        raw_mode;
   } ldcl_cfg_type;

   // One input beat
   typedef struct packed {
      logic [14:0] measured_lux;
      logic [14:0] target_lux;
      logic        direct_mode;
      logic [7:0]  remote_level;
      logic        restart;
   } ldcl_req_type;

   // One result beat
   typedef struct packed {
      logic [9:0]         dim_level;
      logic               enter_saving;
      logic signed [15:0] lux_error;
   } ldcl_rsp_type;

   // Loop state carried from tick to tick
   typedef struct packed {
      logic [9:0]  dim_value;
      logic [22:0] saving_timer;
      logic [7:0]  fast_timer;
      logic [2:0]  step_divider;
      logic [14:0] previous_target;
   } ldcl_state_type;

   typedef logic [9:0] remote_map_type [256];

   function automatic remote_map_type build_remote_map();
      remote_map_type map;
      int unsigned    v;
      for (int i = 0; i < 256; i++) begin
         if (i <= int'(RAW_MAX)) v = (i * RemoteMul) / PerMille;
         else v = PerMille;
         map[i] = 10'(v);
      end
      return map;
   endfunction

   localparam remote_map_type REMOTE_MAP = build_remote_map();

endpackage

FILE: sv/ldcl_csr.sv
// Configuration registers with precomputed timer reload and clamped minimum
module ldcl_csr import ldcl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output ldcl_cfg_type       cfg
);

   logic        ctl_en_ff;
   logic [9:0]  min_level_ff;
   logic [7:0]  percent_ff;
   logic [22:0] reload_ff;
   logic        raw_mode_ff;
   logic [9:0]  min_level_in;

   // Minimum above full scale saturates
   assign min_level_in = (csr_wdata[9:0] > DIM_MAX) ? DIM_MAX : csr_wdata[9:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_en_ff    <= CTL_EN_RESET;
         min_level_ff <= MIN_DIM_RESET;
         percent_ff   <= PERCENT_RESET;
         reload_ff    <= 23'(SECONDS_RESET) * TICKS_PER_SEC;
         raw_mode_ff  <= RAW_MODE_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_CONTROLLER_ENABLE: ctl_en_ff    <= csr_wdata[0];
            CSR_MIN_DIM_LEVEL:     min_level_ff <= min_level_in;
            CSR_SAVING_PERCENT:    percent_ff   <= csr_wdata[7:0];
            CSR_SAVING_SECONDS:    reload_ff    <= 23'(csr_wdata) * TICKS_PER_SEC;
            CSR_REMOTE_RAW_MODE:   raw_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign cfg.ctl_en         = ctl_en_ff;
   assign cfg.min_level      = min_level_ff;
   assign cfg.saving_percent = percent_ff;
   assign cfg.saving_reload  = reload_ff;
   assign cfg.raw_mode       = raw_mode_ff;

endmodule

FILE: sv/ldcl_step.sv
// One control tick: next loop state and result from the current state and input
module ldcl_step import ldcl_pkg::*; (
   input  ldcl_cfg_type   cfg,
   input  ldcl_state_type cur,
   input  ldcl_req_type   req,
   output ldcl_state_type nxt,
   output ldcl_rsp_type   rsp
);

   logic [15:0] meas_ext;
   logic [15:0] target_ext;
   logic [14:0] err_mag;
   logic [14:0] over_diff;
   logic [22:0] over_scaled;
   logic [22:0] margin_scaled;
   logic        over_light;
   logic        rise;
   logic        fall;
   logic        request;
   logic [7:0]  fast_start;
   logic [2:0]  reload;
   logic [9:0]  dim_floor;
   logic [9:0]  remote_dim;

   assign meas_ext   = {1'b0, req.measured_lux};
   assign target_ext = {1'b0, req.target_lux};

   // Error magnitude and direction with deadband
   assign err_mag = (req.target_lux >= req.measured_lux) ?
                    (req.target_lux - req.measured_lux) :
                    (req.measured_lux - req.target_lux);
   assign rise = target_ext > (meas_ext + ERR_DEADBAND);
   assign fall = meas_ext > (target_ext + ERR_DEADBAND);

   // Over-lighting: meas - target > floor(target * pct / 100), compared scaled by 100
   assign over_diff     = req.measured_lux - req.target_lux;
   assign over_scaled   = 23'(over_diff) * PERCENT_SCALE;
   assign margin_scaled = 23'(req.target_lux) * 23'(cfg.saving_percent);
   assign over_light    = (req.measured_lux > req.target_lux) && (over_scaled > margin_scaled);

   // Setpoint change restarts the fast window
   assign fast_start = (req.target_lux != cur.previous_target) ? FAST_TICKS : cur.fast_timer;

   // Remote level mapping
   assign remote_dim = cfg.raw_mode ?
                       ((req.remote_level > RAW_MAX) ? 10'(RAW_MAX) : 10'(req.remote_level)) :
                       REMOTE_MAP[req.remote_level];

   always_comb begin
      nxt       = cur;
      request   = 1'b0;
      reload    = DIV_EVERY_5TH;
      dim_floor = cur.dim_value;
      if (req.restart) begin
         nxt.dim_value    = DIM_RESTART;
         nxt.saving_timer = cfg.saving_reload;
      end else if (cfg.ctl_en && !req.direct_mode) begin
         // Power saving countdown
         if (cfg.saving_percent != 8'd0) begin
            if (over_light) begin
               if (cur.saving_timer > 23'd1) begin
                  nxt.saving_timer = cur.saving_timer - 23'd1;
               end else if (cur.saving_timer == 23'd1) begin
                  nxt.saving_timer = '0;
                  request          = 1'b1;
               end
            end else begin
               nxt.saving_timer = cfg.saving_reload;
            end
         end
         // Step rate selection
         nxt.fast_timer = fast_start;
         if (fast_start != 8'd0) begin
            nxt.fast_timer = fast_start - 8'd1;
            reload         = DIV_EVERY_TICK;
         end else if (err_mag > ERR_FAST_LIMIT) begin
            reload = DIV_EVERY_TICK;
         end else if (err_mag > ERR_MID_LIMIT) begin
            reload = DIV_EVERY_2ND;
         end
         // Dim step
         if (cur.step_divider != 3'd0) begin
            nxt.step_divider = cur.step_divider - 3'd1;
         end else begin
            nxt.step_divider = reload;
            if (rise) begin
               if (cur.dim_value < cfg.min_level) dim_floor = cfg.min_level;
               nxt.dim_value = (dim_floor < DIM_MAX) ? dim_floor + 10'd1 : dim_floor;
            end else if (fall) begin
               nxt.dim_value = (cur.dim_value > cfg.min_level) ? cur.dim_value - 10'd1 : '0;
            end
         end
      end else begin
         nxt.dim_value = remote_dim;
      end
      nxt.previous_target = req.target_lux;
   end

   assign rsp.dim_level    = nxt.dim_value;
   assign rsp.enter_saving = request;
   assign rsp.lux_error    = signed'(target_ext - meas_ext);

endmodule

FILE: sv/lux_dimming_control_loop_core.sv
// Top level of the lux dimming control loop: handshake, pipeline and state registers
// One tick beat is taken every clock cycle while the input side is not stalled. The beat is
// held in an input register, one pass of the step logic computes the new loop state and the
// result together, and both are written at the same edge into the state register and the
// result register, which drives the result port, so the following beat already sees the
// updated state.
// A result waiting on a stalled output does not block the input register from filling;
// the input side stalls only when both registers are full. The loop state comes out of
// reset cleared and needs no clearing pass; configuration writes take effect at once and
// are meant for idle periods.
module lux_dimming_control_loop_core import ldcl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Configuration
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   // Tick input
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [14:0]        req_measured_lux,
   input  logic [14:0]        req_target_lux,
   input  logic               req_direct_mode,
   input  logic [7:0]         req_remote_level,
   input  logic               req_restart,
   // Result output
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_dim_level,
   output logic               rsp_enter_saving,
   output logic signed [15:0] rsp_lux_error
);

   ldcl_cfg_type   cfg;
   ldcl_req_type   in_beat_ff;
   ldcl_state_type state_ff;
   ldcl_state_type state_in;
   ldcl_rsp_type   rsp_ff;
   ldcl_rsp_type   rsp_in;
   logic           in_valid_ff;
   logic           in_valid_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           req_fire;
   logic           out_free;
   logic           advance;

   ldcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ldcl_step u_step (
      .cfg (cfg),
      .cur (state_ff),
      .req (in_beat_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   // Flow control
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign advance      = in_valid_ff && out_free;
   assign req_stall    = in_valid_ff && !out_free;
   assign req_fire     = req_valid && !req_stall;
   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_beat_ff.measured_lux <= req_measured_lux;
         in_beat_ff.target_lux   <= req_target_lux;
         in_beat_ff.direct_mode  <= req_direct_mode;
         in_beat_ff.remote_level <= req_remote_level;
         in_beat_ff.restart      <= req_restart;
      end
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dim_level    = rsp_ff.dim_level;
   assign rsp_enter_saving = rsp_ff.enter_saving;
   assign rsp_lux_error    = rsp_ff.lux_error;

endmodule

FILE: sv/ldcl_checker.sv
// Port-level checks for the lux dimming control loop, bound to the top level
`include "lux_dimming_control_loop_core_macros.svh"

module ldcl_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [9:0]         rsp_dim_level,
   input logic               rsp_enter_saving,
   input logic signed [15:0] rsp_lux_error
);

   // No result straight out of reset
   `LDCL_ASSERT_ALWAYS(a_no_rsp_after_reset, reset |=> !rsp_valid, "result valid after reset")

   // A saving request only comes with over-lighting, so the error is negative
   `LDCL_ASSERT(a_saving_needs_over_light, rsp_valid && rsp_enter_saving |-> rsp_lux_error[15], "saving request without over-lighting")

   // The saving request lasts one tick: the next beat never repeats it
   `LDCL_ASSERT(a_saving_one_tick, rsp_valid && !rsp_stall && rsp_enter_saving |=> !(rsp_valid && rsp_enter_saving), "saving request on consecutive beats")

   // A stalled result holds
   `LDCL_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dim_level) && $stable(rsp_enter_saving) && $stable(rsp_lux_error), "stalled result changed")

endmodule

bind lux_dimming_control_loop_core ldcl_checker u_ldcl_checker (.*);
